[rtl/core/quad_area_heron_macros.svh]
// ----------------------------------------------------------------------------
// quad_area_heron_macros.svh - assertion macros
// Concurrent check wrappers clocked on aclk and muted while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef QUAD_AREA_HERON_MACROS_SVH
`define QUAD_AREA_HERON_MACROS_SVH

// condition holds at every clock edge out of reset
`define QAH_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) else $error(msg);

// antecedent in this cycle implies consequent in the same cycle
`define QAH_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// antecedent in this cycle implies consequent in the next cycle
`define QAH_IMPLIES_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/qah_pkg.sv]
// ----------------------------------------------------------------------------
// qah_pkg - shared constants and width helpers
// Default sizes and the width rules that tie lanes, multipliers and roots.
// ----------------------------------------------------------------------------
`default_nettype none

package qah_pkg;

    // defaults for the top level parameters
    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;

    // fixed field widths of the stream
    localparam int FIELD_W   = 32;
    localparam int NUM_VERT  = 4;
    localparam int NUM_AXIS  = 3;
    localparam int AREA_W    = 52;
    localparam int IN_DATA_W = 384;
    localparam int OUT_DATA_W = 56;

    // operand slice of one partial product
    localparam int MUL_CHUNK = 32;

    // side length: sqrt of three squares of a (cw+1)-bit magnitude
    function automatic int len_w(input int cw);
        return cw + 1;
    endfunction

    // Heron factor: sum of three lengths
    function automatic int fac_w(input int cw);
        return cw + 3;
    endfunction

    // root of the product of four factors
    function automatic int root_w(input int cw);
        return 2 * (cw + 3);
    endfunction

endpackage

`default_nettype wire

[rtl/core/quad_area_heron.sv]
// ----------------------------------------------------------------------------
// quad_area_heron - quadrilateral area by Heron's formula
// Five length lanes and two triangle lanes in parallel, merged into Q36.16.
// ----------------------------------------------------------------------------
//  channel | direction | tdata                           | tuser
//  s_      | in        | p0_x..p3_z, 32 bits each         | -
//  m_      | out       | area [51:0], zero padded to 56   | radicand_clamped
//
// One transaction per cycle is accepted and one result leaves per cycle
// unless stalled. Depth is set by the length root (COORD_WIDTH+1 stages), the
// factor product multipliers and the triangle root (2*COORD_WIDTH+6 stages).
// A stalled output register freezes the whole pipeline; s_tready then drops.
// Synchronous active-low reset clears all valid flags; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

`include "quad_area_heron_macros.svh"

module quad_area_heron #(
    parameter int COORD_WIDTH = qah_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = qah_pkg::FRAC_BITS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // p0_x, p0_y, p0_z, p1_x, ..., p3_z from bit 0 up, 32 bits each
    input  wire logic [qah_pkg::IN_DATA_W-1:0]     s_tdata,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // area [51:0], zeros above
    output logic      [qah_pkg::OUT_DATA_W-1:0]    m_tdata,
    // radicand_clamped
    output logic                                   m_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready
);

    localparam int LW   = qah_pkg::len_w(COORD_WIDTH);
    localparam int TW   = qah_pkg::root_w(COORD_WIDTH);
    localparam int SUMW = TW + 1;
    localparam int XW   = (SUMW > qah_pkg::AREA_W) ? SUMW : qah_pkg::AREA_W + 1;
    localparam int SH   = FRAC_BITS + 2;

    // lane 0 is the diagonal, then sides 01, 12, 23, 30
    localparam int LANE_P [5] = '{0, 0, 1, 2, 3};
    localparam int LANE_Q [5] = '{2, 1, 2, 3, 0};

    logic [3:0][2:0][COORD_WIDTH-1:0] crd;
    logic [LW-1:0]                    len [5];
    logic [4:0]                       len_vld;
    logic                             en;
    logic [TW-1:0]                    t0, t1;
    logic                             t0_vld, t1_vld, t0_clamp, t1_clamp;
    logic [XW-1:0]                    sum_x;
    logic [XW-1:0]                    sum_sh;
    logic                             sat;
    logic [qah_pkg::AREA_W-1:0]       area_reg;
    logic                             clamp_reg;
    logic                             m_tvalid_reg;

    // pipeline advances unless a result waits at the output
    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    // low COORD_WIDTH bits of each field, sign taken from the top one
    genvar v, k, l;
    for (v = 0; v < qah_pkg::NUM_VERT; v++) begin : g_vert
        for (k = 0; k < qah_pkg::NUM_AXIS; k++) begin : g_axis
            assign crd[v][k] =
                s_tdata[(v*qah_pkg::NUM_AXIS + k)*qah_pkg::FIELD_W +: COORD_WIDTH];
        end
    end

    // length lanes
    for (l = 0; l < 5; l++) begin : g_len
        qah_len #(.CW(COORD_WIDTH)) u_len (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .p       (crd[LANE_P[l]]),
            .q       (crd[LANE_Q[l]]),
            .vld_in  (s_tvalid),
            .len     (len[l]),
            .vld_out (len_vld[l])
        );
    end

    // triangle (p0,p1,p2)
    qah_tri #(.CW(COORD_WIDTH)) u_tri0 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .a         (len[1]),
        .b         (len[2]),
        .c         (len[0]),
        .vld_in    (&len_vld),
        .t         (t0),
        .vld_out   (t0_vld),
        .clamp_out (t0_clamp)
    );

    // triangle (p2,p3,p0)
    qah_tri #(.CW(COORD_WIDTH)) u_tri1 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .a         (len[3]),
        .b         (len[4]),
        .c         (len[0]),
        .vld_in    (&len_vld),
        .t         (t1),
        .vld_out   (t1_vld),
        .clamp_out (t1_clamp)
    );

    // merge: sum, drop 2+FRAC_BITS bits, saturate
    assign sum_x  = XW'(t0) + XW'(t1);
    assign sum_sh = sum_x >> SH;
    assign sat    = |(sum_sh >> qah_pkg::AREA_W);

    always_ff @(posedge aclk) begin
        if (en) begin
            area_reg  <= sat ? '1 : sum_sh[qah_pkg::AREA_W-1:0];
            clamp_reg <= t0_clamp | t1_clamp;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= t0_vld & t1_vld;
        end
    end

    assign m_tdata  = qah_pkg::OUT_DATA_W'(area_reg);
    assign m_tuser  = clamp_reg;
    assign m_tvalid = m_tvalid_reg;

    // checks
    `QAH_ALWAYS(a_len_lanes_agree, (len_vld == '0) || (&len_vld), "length lanes out of step")
    `QAH_ALWAYS(a_tri_lanes_agree, t0_vld == t1_vld, "triangle lanes out of step")
    `QAH_IMPLIES(a_stall_blocks_input, m_tvalid && !m_tready, !s_tready, "input taken during stall")
    `QAH_IMPLIES_NEXT(a_merge_to_output, t0_vld && en, m_tvalid, "merged result lost")

endmodule

`default_nettype wire

[rtl/core/qah_mul.sv]
// ----------------------------------------------------------------------------
// qah_mul - pipelined unsigned multiplier
// One partial product of two operand chunks per stage, accumulated in place.
// ----------------------------------------------------------------------------
`default_nettype none

module qah_mul #(
    parameter int AW = 36,
    parameter int BW = 36,
    parameter int TW = 1,
    parameter int CH = qah_pkg::MUL_CHUNK
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               en,
    input  wire logic [AW-1:0]      a,
    input  wire logic [BW-1:0]      b,
    input  wire logic [TW-1:0]      tag_in,
    output logic      [AW+BW-1:0]   p,
    output logic      [TW-1:0]      tag_out
);

    localparam int NA = (AW + CH - 1) / CH;
    localparam int NB = (BW + CH - 1) / CH;
    localparam int NS = NA * NB;
    localparam int XW = NA * CH;
    localparam int YW = NB * CH;
    localparam int PW = AW + BW;

    logic [XW-1:0] a_reg   [NS];
    logic [YW-1:0] b_reg   [NS];
    logic [PW-1:0] acc_reg [NS];
    logic [TW-1:0] tag_reg [NS];

    genvar s;
    for (s = 0; s < NS; s++) begin : g_stage
        localparam int IA = s % NA;
        localparam int IB = s / NA;
        localparam int SH = (IA + IB) * CH;

        logic [XW-1:0]   a_cur;
        logic [YW-1:0]   b_cur;
        logic [PW-1:0]   acc_cur;
        logic [TW-1:0]   tag_cur;
        logic [2*CH-1:0] pp;

        if (s == 0) begin : g_first
            assign a_cur   = XW'(a);
            assign b_cur   = YW'(b);
            assign acc_cur = '0;
            assign tag_cur = tag_in;
        end else begin : g_next
            assign a_cur   = a_reg[s-1];
            assign b_cur   = b_reg[s-1];
            assign acc_cur = acc_reg[s-1];
            assign tag_cur = tag_reg[s-1];
        end

        // one chunk-by-chunk product per stage
        assign pp = a_cur[IA*CH +: CH] * b_cur[IB*CH +: CH];

        always_ff @(posedge aclk) begin
            if (en) begin
                a_reg[s]   <= a_cur;
                b_reg[s]   <= b_cur;
                acc_reg[s] <= acc_cur + (PW'(pp) << SH);
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                tag_reg[s] <= '0;
            end else if (en) begin
                tag_reg[s] <= tag_cur;
            end
        end
    end

    assign p       = acc_reg[NS-1];
    assign tag_out = tag_reg[NS-1];

endmodule

`default_nettype wire

[rtl/core/qah_sqrt.sv]
// ----------------------------------------------------------------------------
// qah_sqrt - pipelined integer square root
// Restoring digit recurrence, one root bit per stage, floor result.
// ----------------------------------------------------------------------------
`default_nettype none

module qah_sqrt #(
    parameter int NW = 66,
    parameter int TW = 1
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             en,
    input  wire logic [NW-1:0]    rad,
    input  wire logic [TW-1:0]    tag_in,
    output logic      [NW/2-1:0]  root,
    output logic      [TW-1:0]    tag_out
);

    localparam int RW = NW / 2;
    localparam int MW = RW + 3;

    logic [NW-1:0] rad_reg  [RW];
    logic [MW-1:0] rem_reg  [RW];
    logic [RW-1:0] root_reg [RW];
    logic [TW-1:0] tag_reg  [RW];

    genvar s;
    for (s = 0; s < RW; s++) begin : g_stage
        logic [NW-1:0] rad_cur;
        logic [MW-1:0] rem_cur;
        logic [RW-1:0] root_cur;
        logic [TW-1:0] tag_cur;
        logic [MW-1:0] rem_sh;
        logic [MW-1:0] trial;
        logic          ge;

        if (s == 0) begin : g_first
            assign rad_cur  = rad;
            assign rem_cur  = '0;
            assign root_cur = '0;
            assign tag_cur  = tag_in;
        end else begin : g_next
            assign rad_cur  = rad_reg[s-1];
            assign rem_cur  = rem_reg[s-1];
            assign root_cur = root_reg[s-1];
            assign tag_cur  = tag_reg[s-1];
        end

        // bring down two radicand bits, try root*4+1
        assign rem_sh = {rem_cur[MW-3:0], rad_cur[NW-1 -: 2]};
        assign trial  = MW'({root_cur, 2'b01});
        assign ge     = (rem_sh >= trial);

        always_ff @(posedge aclk) begin
            if (en) begin
                rad_reg[s]  <= rad_cur << 2;
                rem_reg[s]  <= ge ? (rem_sh - trial) : rem_sh;
                root_reg[s] <= {root_cur[RW-2:0], ge};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                tag_reg[s] <= '0;
            end else if (en) begin
                tag_reg[s] <= tag_cur;
            end
        end
    end

    assign root    = root_reg[RW-1];
    assign tag_out = tag_reg[RW-1];

endmodule

`default_nettype wire

[rtl/core/qah_len.sv]
// ----------------------------------------------------------------------------
// qah_len - segment length lane
// Per-axis differences, squares, their sum and the floor square root.
// ----------------------------------------------------------------------------
`default_nettype none

module qah_len #(
    parameter int CW = qah_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          en,
    input  wire logic [2:0][CW-1:0]            p,
    input  wire logic [2:0][CW-1:0]            q,
    input  wire logic                          vld_in,
    output logic      [qah_pkg::len_w(CW)-1:0] len,
    output logic                               vld_out
);

    localparam int DW = CW + 1;
    localparam int SW = 2 * DW;

    logic [2:0][DW-1:0] mag;
    logic [2:0][SW-1:0] sq;
    logic [2:0]         sq_vld;
    logic [SW-1:0]      sum_reg;
    logic               sum_vld_reg;

    genvar k;
    for (k = 0; k < 3; k++) begin : g_axis
        logic signed [DW-1:0] d;

        // absolute difference, fits unsigned in DW bits
        assign d      = $signed({q[k][CW-1], q[k]}) - $signed({p[k][CW-1], p[k]});
        assign mag[k] = d[DW-1] ? DW'(-d) : DW'(d);

        qah_mul #(.AW(DW), .BW(DW), .TW(1)) u_sq (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .a       (mag[k]),
            .b       (mag[k]),
            .tag_in  (vld_in),
            .p       (sq[k]),
            .tag_out (sq_vld[k])
        );
    end

    // sum of squares
    always_ff @(posedge aclk) begin
        if (en) begin
            sum_reg <= sq[0] + sq[1] + sq[2];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_vld_reg <= 1'b0;
        end else if (en) begin
            sum_vld_reg <= &sq_vld;
        end
    end

    qah_sqrt #(.NW(SW), .TW(1)) u_root (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .rad     (sum_reg),
        .tag_in  (sum_vld_reg),
        .root    (len),
        .tag_out (vld_out)
    );

endmodule

`default_nettype wire

[rtl/core/qah_tri.sv]
// ----------------------------------------------------------------------------
// qah_tri - Heron triangle lane
// Four Heron factors, their exact product, and floor sqrt (16*area^2).
// ----------------------------------------------------------------------------
`default_nettype none

module qah_tri #(
    parameter int CW = qah_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           en,
    input  wire logic [qah_pkg::len_w(CW)-1:0]  a,
    input  wire logic [qah_pkg::len_w(CW)-1:0]  b,
    input  wire logic [qah_pkg::len_w(CW)-1:0]  c,
    input  wire logic                           vld_in,
    output logic      [qah_pkg::root_w(CW)-1:0] t,
    output logic                                vld_out,
    output logic                                clamp_out
);

    localparam int FW = qah_pkg::fac_w(CW);
    localparam int GW = FW + 1;

    logic signed [GW-1:0] ae, be, ce;
    logic signed [GW-1:0] f0, f1, f2, f3;
    logic                 neg;
    logic [FW-1:0]        fac_reg [4];
    logic [1:0]           tag_reg;
    logic [2*FW-1:0]      p01, p23;
    logic [1:0]           tag01, tag23;
    logic [4*FW-1:0]      prod;
    logic [1:0]           tag_prod;
    logic [1:0]           tag_root;

    // Heron factors, a negative one means a degenerate triangle
    assign ae  = $signed(GW'(a));
    assign be  = $signed(GW'(b));
    assign ce  = $signed(GW'(c));
    assign f0  = ae + be + ce;
    assign f1  = be + ce - ae;
    assign f2  = ae - be + ce;
    assign f3  = ae + be - ce;
    assign neg = f1[GW-1] | f2[GW-1] | f3[GW-1];

    always_ff @(posedge aclk) begin
        if (en) begin
            fac_reg[0] <= neg ? '0 : f0[FW-1:0];
            fac_reg[1] <= neg ? '0 : f1[FW-1:0];
            fac_reg[2] <= neg ? '0 : f2[FW-1:0];
            fac_reg[3] <= neg ? '0 : f3[FW-1:0];
        end
    end

    // tag bit 1: clamp, bit 0: valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_reg <= '0;
        end else if (en) begin
            tag_reg <= {neg & vld_in, vld_in};
        end
    end

    qah_mul #(.AW(FW), .BW(FW), .TW(2)) u_mul01 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .a       (fac_reg[0]),
        .b       (fac_reg[1]),
        .tag_in  (tag_reg),
        .p       (p01),
        .tag_out (tag01)
    );

    qah_mul #(.AW(FW), .BW(FW), .TW(2)) u_mul23 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .a       (fac_reg[2]),
        .b       (fac_reg[3]),
        .tag_in  (tag_reg),
        .p       (p23),
        .tag_out (tag23)
    );

    qah_mul #(.AW(2*FW), .BW(2*FW), .TW(2)) u_mul_all (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .a       (p01),
        .b       (p23),
        .tag_in  (tag01 & tag23),
        .p       (prod),
        .tag_out (tag_prod)
    );

    qah_sqrt #(.NW(4*FW), .TW(2)) u_root (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .rad     (prod),
        .tag_in  (tag_prod),
        .root    (t),
        .tag_out (tag_root)
    );

    assign vld_out   = tag_root[0];
    assign clamp_out = tag_root[1];

endmodule

`default_nettype wire

[verif/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - self-checking bench for quad_area_heron
// Drives quadrilaterals over the s_ stream, predicts each area and clamp flag
// with exact wide integer arithmetic, and compares results in order on m_.
// Both sides idle in random bursts; one long output hold fills the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

    localparam int N_RANDOM = 400;
    localparam int N_CALM   = 60;
    localparam int DRAIN    = 400;

    typedef logic signed [31:0] coord_t;
    typedef coord_t quad_t [12];

    typedef struct packed {
        logic [51:0] area;
        logic        clamp;
    } area_res_t;

    typedef struct {
        coord_t    c [12];
        bit        typed;
        area_res_t res;
    } stim_row_t;

    logic                             aclk = 1'b0;
    logic                             aresetn = 1'b0;
    logic [qah_pkg::IN_DATA_W-1:0]    s_tdata = '0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [qah_pkg::OUT_DATA_W-1:0]   m_tdata;
    logic                             m_tuser;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;

    area_res_t area_q [$];
    area_res_t offered_res;
    int        n_errors = 0;
    bit        calm = 1'b0;
    bit        hold_req = 1'b0;

    quad_area_heron dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    always #1 aclk = ~aclk;

    // floor square root of a value below 2^192
    function automatic logic [95:0] isqrt(input logic [191:0] n);
        logic [95:0]  r;
        logic [95:0]  tr;
        logic [191:0] sq;
        r = '0;
        for (int b = 95; b >= 0; b--) begin
            tr = r | (96'd1 << b);
            sq = 192'(tr) * 192'(tr);
            if (sq <= n) r = tr;
        end
        return r;
    endfunction

    function automatic logic [63:0] edge_len(input quad_t c, input int i, input int j);
        logic [191:0]     acc;
        logic signed [33:0] d;
        logic [33:0]      m;
        logic [95:0]      r;
        acc = '0;
        for (int k = 0; k < 3; k++) begin
            d = 34'(c[j*3+k]) - 34'(c[i*3+k]);
            m = d[33] ? -d : d;
            acc += 192'(m) * 192'(m);
        end
        r = isqrt(acc);
        return r[63:0];
    endfunction

    // 4*area of one triangle, scaled by 2^(2*FRAC); sets clamp on a negative factor
    function automatic logic [95:0] heron_term(input logic [63:0] a, input logic [63:0] b,
                                               input logic [63:0] c, inout logic clamp);
        longint       f [4];
        logic [191:0] p;
        f[0] = a + b + c;
        f[1] = -longint'(a) + b + c;
        f[2] = longint'(a) - b + c;
        f[3] = longint'(a) + b - c;
        for (int k = 0; k < 4; k++)
            if (f[k] < 0) begin
                clamp = 1'b1;
                return '0;
            end
        p = 192'd1;
        for (int k = 0; k < 4; k++) p = p * 192'(f[k]);
        return isqrt(p);
    endfunction

    function automatic area_res_t predict_area(input quad_t c);
        logic [63:0] ab, bc, cd, da, dg;
        logic [96:0] s;
        area_res_t   r;
        r.clamp = 1'b0;
        dg = edge_len(c, 0, 2);
        ab = edge_len(c, 0, 1);
        bc = edge_len(c, 1, 2);
        cd = edge_len(c, 2, 3);
        da = edge_len(c, 3, 0);
        s = 97'(heron_term(ab, bc, dg, r.clamp)) + 97'(heron_term(cd, da, dg, r.clamp));
        s = s >> (qah_pkg::FRAC_BITS_DEF + 2);
        r.area = (s >> 52) != 0 ? {52{1'b1}} : s[51:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
        n_errors++;
    endtask

    // scoreboard: queue expectations on accepted input, check on accepted output
    always @(posedge aclk) begin
        area_res_t e;
        if (aresetn && s_tvalid && s_tready) area_q.push_back(offered_res);
        if (aresetn && m_tvalid && m_tready) begin
            if (area_q.size() == 0) begin
                report_mismatch("unexpected transaction", m_tdata, 0);
            end else begin
                e = area_q.pop_front();
                if (m_tdata[51:0] !== e.area) report_mismatch("area", m_tdata[51:0], e.area);
                if (m_tdata[55:52] !== 4'd0) report_mismatch("pad", m_tdata[55:52], 0);
                if (m_tuser !== e.clamp) report_mismatch("clamp", m_tuser, e.clamp);
            end
        end
    end

    // receiver: random stall bursts, one long hold on request, none when calm
    initial begin
        int n;
        @(posedge aclk iff aresetn);
        forever begin
            if (calm) begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end else if (hold_req) begin
                m_tready <= 1'b0;
                repeat (300) @(posedge aclk);
                hold_req = 1'b0;
            end else begin
                n = $urandom_range(1, 14);
                m_tready <= 1'b0;
                repeat (n) @(posedge aclk);
                m_tready <= 1'b1;
                n = $urandom_range(1, 40);
                repeat (n) @(posedge aclk);
            end
        end
    end

    task automatic offer(input quad_t c, input area_res_t r);
        int                            gap;
        logic [qah_pkg::IN_DATA_W-1:0] d;
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 14);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        d = '0;
        for (int k = 0; k < 12; k++) d[k*32 +: 32] = c[k];
        s_tdata     <= d;
        s_tvalid    <= 1'b1;
        offered_res <= r;
        do @(posedge aclk); while (!s_tready);
    endtask

    function automatic coord_t rand_coord(input int mode);
        case (mode)
            0: return coord_t'($urandom);
            1: return coord_t'($urandom_range(0, 1 << 20)) - coord_t'(1 << 19);
            default: return coord_t'($urandom_range(0, 8)) - 4;
        endcase
    endfunction

    // stimulus
    initial begin
        stim_row_t rows [$];
        stim_row_t row;
        quad_t     q;
        int        mode, t;

        // all at origin: zero area
        row.typed = 1'b1; row.res = '{area: 0, clamp: 0};
        foreach (row.c[k]) row.c[k] = 0;
        rows.push_back(row);
        // collinear, rounded lengths make a+b-c negative on the first triangle
        row.c = '{0, 0, 0, 1, 1, 0, 3, 3, 0, 0, 0, 0};
        row.res = '{area: 0, clamp: 1};
        rows.push_back(row);
        // predicted rows: extremes and ordinary shapes
        row.typed = 1'b0;
        row.c = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                  32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000,
                  32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
                  32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff};
        rows.push_back(row);
        row.c = '{32'sh8000_0000, 32'sh7fff_ffff, 0, 32'sh7fff_ffff, 32'sh8000_0000, 0,
                  32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000,
                  32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff};
        rows.push_back(row);
        row.c = '{-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1};
        rows.push_back(row);
        // unit square in Q16.16
        row.c = '{0, 0, 0, 65536, 0, 0, 65536, 65536, 0, 0, 65536, 0};
        rows.push_back(row);
        // planar, tilted out of the xy plane
        row.c = '{0, 0, 0, 65536, 0, 65536, 65536, 65536, 0, 0, 65536, -65536};
        rows.push_back(row);
        row.c = '{1, 0, 0, 0, 1, 0, 0, 0, 1, 1, 1, 1};
        rows.push_back(row);

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (rows[i]) begin
            foreach (q[k]) q[k] = rows[i].c[k];
            offer(q, rows[i].typed ? rows[i].res : predict_area(q));
        end

        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == 150) hold_req = 1'b1;
            if (i == N_RANDOM - N_CALM) calm = 1'b1;
            mode = $urandom_range(0, 2);
            foreach (q[k]) q[k] = rand_coord(mode);
            // collinear p0, p1, p2 can hit the clamp path
            if ($urandom_range(0, 5) == 0) begin
                for (int k = 0; k < 3; k++) begin
                    t = $urandom_range(0, 3);
                    q[3+k] = q[k] + t;
                    q[6+k] = q[k] + 3 * t;
                end
            end
            offer(q, predict_area(q));
        end
        s_tvalid <= 1'b0;
        calm = 1'b1;

        while (area_q.size() != 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
        if (n_errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire
